### design/stw_pkg.sv
// Shared types, constants and lookup functions for the stopwatch time display core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package stw_pkg;

	localparam int WORD_W = 32;
	localparam int DIV_W  = 27;
	localparam int PART_W = 7;

	// Which part of the elapsed time is shown.
	typedef logic [2:0] part_sel_t;
	localparam part_sel_t SEL_HUND = 3'd0;
	localparam part_sel_t SEL_SEC  = 3'd1;
	localparam part_sel_t SEL_MIN  = 3'd2;
	localparam part_sel_t SEL_HOUR = 3'd3;
	localparam part_sel_t SEL_DAY  = 3'd4;

	// Bit of the centre (run/stop) button.
	localparam int CENTRE_BIT = 4;

	// Item data that rides along the divider pipeline.
	typedef struct packed {
		part_sel_t  sel;
		logic       enc_mode;
		logic [7:0] enc;
	} side_t;

	localparam logic [DIV_W-1:0] MS_PER_HUND = 27'd10;
	localparam logic [DIV_W-1:0] MS_PER_SEC  = 27'd1000;
	localparam logic [DIV_W-1:0] MS_PER_MIN  = 27'd60000;
	localparam logic [DIV_W-1:0] MS_PER_HOUR = 27'd3600000;
	localparam logic [DIV_W-1:0] MS_PER_DAY  = 27'd86400000;

	localparam logic [DIV_W-1:0] MOD_HUND = 27'd100;
	localparam logic [DIV_W-1:0] MOD_SEC  = 27'd60;
	localparam logic [DIV_W-1:0] MOD_HOUR = 27'd24;
	// The day count never reaches 50, so reducing it modulo 128 leaves it unchanged.
	localparam logic [DIV_W-1:0] MOD_DAY  = 27'd128;

	// Reciprocals floor(2^32 / d); the estimate they give is low by at most one.
	localparam logic [63:0] RECIP_ONE = 64'd1 << 32;
	localparam logic [31:0] RCP_HUND     = 32'(RECIP_ONE / 64'd10);
	localparam logic [31:0] RCP_SEC      = 32'(RECIP_ONE / 64'd1000);
	localparam logic [31:0] RCP_MIN      = 32'(RECIP_ONE / 64'd60000);
	localparam logic [31:0] RCP_HOUR     = 32'(RECIP_ONE / 64'd3600000);
	localparam logic [31:0] RCP_DAY      = 32'(RECIP_ONE / 64'd86400000);
	localparam logic [31:0] RCP_MOD_HUND = 32'(RECIP_ONE / 64'd100);
	localparam logic [31:0] RCP_MOD_SEC  = 32'(RECIP_ONE / 64'd60);
	localparam logic [31:0] RCP_MOD_HOUR = 32'(RECIP_ONE / 64'd24);
	localparam logic [31:0] RCP_MOD_DAY  = 32'(RECIP_ONE / 64'd128);

	function automatic logic [DIV_W-1:0] part_divisor(input part_sel_t sel);
		logic [DIV_W-1:0] d;
		unique case (sel)
			SEL_SEC:  d = MS_PER_SEC;
			SEL_MIN:  d = MS_PER_MIN;
			SEL_HOUR: d = MS_PER_HOUR;
			SEL_DAY:  d = MS_PER_DAY;
			default:  d = MS_PER_HUND;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] part_recip(input part_sel_t sel);
		logic [31:0] r;
		unique case (sel)
			SEL_SEC:  r = RCP_SEC;
			SEL_MIN:  r = RCP_MIN;
			SEL_HOUR: r = RCP_HOUR;
			SEL_DAY:  r = RCP_DAY;
			default:  r = RCP_HUND;
		endcase
		return r;
	endfunction

	function automatic logic [DIV_W-1:0] part_modulus(input part_sel_t sel);
		logic [DIV_W-1:0] m;
		unique case (sel)
			SEL_SEC:  m = MOD_SEC;
			SEL_MIN:  m = MOD_SEC;
			SEL_HOUR: m = MOD_HOUR;
			SEL_DAY:  m = MOD_DAY;
			default:  m = MOD_HUND;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] part_mod_recip(input part_sel_t sel);
		logic [31:0] r;
		unique case (sel)
			SEL_SEC:  r = RCP_MOD_SEC;
			SEL_MIN:  r = RCP_MOD_SEC;
			SEL_HOUR: r = RCP_MOD_HOUR;
			SEL_DAY:  r = RCP_MOD_DAY;
			default:  r = RCP_MOD_HUND;
		endcase
		return r;
	endfunction

endpackage

### design/stw_track.sv
// Run/stop tracking: keeps the base time, held time and button history and
// registers the elapsed time of each sample. Depends on stw_pkg.
`timescale 1ns / 1ps

module stw_track (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                timer_now,
	input  logic [4:0]                 buttons,
	input  logic [3:0]                 switches,
	input  logic [7:0]                 encoder_value,
	input  logic                       encoder_mode,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [stw_pkg::WORD_W-1:0] elapsed,
	output stw_pkg::side_t             side
);
	import stw_pkg::*;

	logic              frozen_q;
	logic              primed_q;
	logic [31:0]       base_q;
	logic [31:0]       held_q;
	logic [4:0]        prev_q;
	logic              v_s1;
	logic [31:0]       elapsed_s1;
	side_t             side_s1;

	logic              en;
	logic              accept;
	logic [31:0]       base_eff;
	logic              prev_centre;
	logic              rise;
	logic [31:0]       run_elapsed;
	part_sel_t         sel;

	assign en       = !v_s1 || !out_stall;
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// Before the first sample the baseline is the sample itself.
	assign base_eff    = primed_q ? base_q : timer_now;
	assign prev_centre = primed_q ? prev_q[CENTRE_BIT] : buttons[CENTRE_BIT];
	assign rise        = !prev_centre && buttons[CENTRE_BIT];
	assign run_elapsed = timer_now - base_eff;

	always_comb begin
		if (switches[3]) begin
			sel = SEL_DAY;
		end else if (switches[2]) begin
			sel = SEL_HOUR;
		end else if (switches[1]) begin
			sel = SEL_MIN;
		end else if (switches[0]) begin
			sel = SEL_SEC;
		end else begin
			sel = SEL_HUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frozen_q <= 1'b0;
			primed_q <= 1'b0;
			base_q   <= '0;
			held_q   <= '0;
			prev_q   <= '0;
		end else if (accept) begin
			primed_q <= 1'b1;
			prev_q   <= buttons;
			if (!frozen_q) begin
				held_q <= run_elapsed;
			end
			if (rise && frozen_q) begin
				frozen_q <= 1'b0;
				base_q   <= timer_now - held_q;
			end else if (rise) begin
				frozen_q <= 1'b1;
				base_q   <= timer_now;
			end else begin
				base_q <= base_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_s1        <= frozen_q ? held_q : run_elapsed;
			side_s1.sel       <= sel;
			side_s1.enc_mode  <= encoder_mode;
			side_s1.enc       <= encoder_value;
		end
	end

	assign out_valid = v_s1;
	assign elapsed   = elapsed_s1;
	assign side      = side_s1;

endmodule

### design/stw_cdiv.sv
// Three-stage divider by a per-item constant, using a reciprocal multiply,
// a back multiply and a single correction step. Depends on stw_pkg.
`timescale 1ns / 1ps

module stw_cdiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [stw_pkg::WORD_W-1:0] dividend,
	input  logic [stw_pkg::DIV_W-1:0]  divisor,
	input  logic [31:0]                recip,
	input  stw_pkg::side_t             side_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [stw_pkg::WORD_W-1:0] quotient,
	output logic [stw_pkg::DIV_W-1:0]  remainder,
	output stw_pkg::side_t             side_out
);
	import stw_pkg::*;

	logic                v_s1, v_s2, v_s3;
	logic                en1, en2, en3;

	logic [WORD_W-1:0]   qe_s1, num_s1;
	logic [DIV_W-1:0]    div_s1;
	side_t               side_s1;

	logic [WORD_W-1:0]   qe_s2, num_s2, back_s2;
	logic [DIV_W-1:0]    div_s2;
	side_t               side_s2;

	logic [WORD_W-1:0]   q_s3;
	logic [DIV_W-1:0]    rem_s3;
	side_t               side_s3;

	logic [63:0]         prod;
	logic [WORD_W-1:0]   back;
	logic [WORD_W-1:0]   r_raw;
	logic [WORD_W-1:0]   div_ext;
	logic                over;

	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	assign prod    = {32'd0, dividend} * {32'd0, recip};
	assign back    = qe_s1 * {{(WORD_W-DIV_W){1'b0}}, div_s1};
	assign div_ext = {{(WORD_W-DIV_W){1'b0}}, div_s2};
	assign r_raw   = num_s2 - back_s2;
	assign over    = r_raw >= div_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			qe_s1   <= prod[63:32];
			num_s1  <= dividend;
			div_s1  <= divisor;
			side_s1 <= side_in;
		end
		if (en2 && v_s1) begin
			qe_s2   <= qe_s1;
			num_s2  <= num_s1;
			div_s2  <= div_s1;
			back_s2 <= back;
			side_s2 <= side_s1;
		end
		if (en3 && v_s2) begin
			q_s3    <= over ? qe_s2 + 32'd1 : qe_s2;
			rem_s3  <= over ? DIV_W'(r_raw - div_ext) : r_raw[DIV_W-1:0];
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign quotient  = q_s3;
	assign remainder = rem_s3;
	assign side_out  = side_s3;

endmodule

### design/stw_fmt.sv
// Output stage: turns the selected time part into two BCD digits and an LED
// value, or passes the encoder value through. Depends on stw_pkg.
`timescale 1ns / 1ps

module stw_fmt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [stw_pkg::PART_W-1:0] part,
	input  stw_pkg::side_t             side,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 segment_code,
	output logic [7:0]                 led_value
);
	import stw_pkg::*;

	logic          v_s1;
	logic [7:0]    seg_s1;
	logic [7:0]    led_s1;
	logic          en;
	logic [14:0]   tens_prod;
	logic [3:0]    tens;
	logic [PART_W-1:0] units;

	assign en       = !v_s1 || !out_stall;
	assign in_stall = !en;

	// Multiplying by 205 and dropping 11 bits divides by ten for parts below 100.
	assign tens_prod = {8'd0, part} * 15'd205;
	assign tens      = tens_prod[14:11];
	assign units     = part - PART_W'({3'd0, tens} * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			if (side.enc_mode) begin
				seg_s1 <= side.enc;
				led_s1 <= side.enc;
			end else begin
				seg_s1 <= {tens, units[3:0]};
				led_s1 <= {1'b0, part};
			end
		end
	end

	assign out_valid    = v_s1;
	assign segment_code = seg_s1;
	assign led_value    = led_s1;

endmodule

### design/stopwatch_time_display_core.sv
// Stopwatch time display core: top level that chains the run/stop tracker,
// two constant dividers and the digit formatter. Depends on stw_pkg.
`timescale 1ns / 1ps

// Each input beat is one poll sample (millisecond timer, buttons, switches,
// encoder value and encoder-mode flag) and produces exactly one output beat
// carrying a two-digit BCD code and a binary LED value, or the encoder value
// in both in encoder mode. The block accepts one beat every clock cycle when
// the output side is not stalled. The sample passes through eight registers:
// the run/stop tracker captures it at the accepting edge, then three stages in
// the divider that turns milliseconds into the selected unit, three in the
// divider that reduces that count modulo 100, 60, 24 or 128, and one in the
// output formatter. Each divider stage holds one 32-bit multiplier at most,
// which is what sets the pipeline depth. Stall propagates back through the
// stages only where a stage is full, so bubbles are absorbed.
// The first sample after reset sets the time base and shows zero elapsed time;
// a rising edge on the centre button toggles between running and frozen, and
// that keeps working in encoder mode. There is no register interface and no
// clearing pass after reset.

module stopwatch_time_display_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] timer_now,
	input  logic [4:0]  buttons,
	input  logic [3:0]  switches,
	input  logic [7:0]  encoder_value,
	input  logic        encoder_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  segment_code,
	output logic [7:0]  led_value
);
	import stw_pkg::*;

	// Tracker to unit divider.
	logic              trk_valid;
	logic              trk_stall;
	logic [WORD_W-1:0] trk_elapsed;
	side_t             trk_side;

	// Unit divider to modulo divider.
	logic              unit_valid;
	logic              unit_stall;
	logic [WORD_W-1:0] unit_count;
	side_t             unit_side;

	// Modulo divider to formatter.
	logic              mod_valid;
	logic              mod_stall;
	logic [DIV_W-1:0]  mod_rem;
	side_t             mod_side;

	stw_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.timer_now     (timer_now),
		.buttons       (buttons),
		.switches      (switches),
		.encoder_value (encoder_value),
		.encoder_mode  (encoder_mode),
		.out_valid     (trk_valid),
		.out_stall     (trk_stall),
		.elapsed       (trk_elapsed),
		.side          (trk_side)
	);

	// Milliseconds divided down to hundredths, seconds, minutes, hours or days.
	stw_cdiv u_unit_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (trk_valid),
		.in_stall  (trk_stall),
		.dividend  (trk_elapsed),
		.divisor   (part_divisor(trk_side.sel)),
		.recip     (part_recip(trk_side.sel)),
		.side_in   (trk_side),
		.out_valid (unit_valid),
		.out_stall (unit_stall),
		.quotient  (unit_count),
		.remainder (),
		.side_out  (unit_side)
	);

	// The unit count reduced to the range of its display position.
	stw_cdiv u_mod_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (unit_valid),
		.in_stall  (unit_stall),
		.dividend  (unit_count),
		.divisor   (part_modulus(unit_side.sel)),
		.recip     (part_mod_recip(unit_side.sel)),
		.side_in   (unit_side),
		.out_valid (mod_valid),
		.out_stall (mod_stall),
		.quotient  (),
		.remainder (mod_rem),
		.side_out  (mod_side)
	);

	stw_fmt u_fmt (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (mod_valid),
		.in_stall     (mod_stall),
		.part         (mod_rem[PART_W-1:0]),
		.side         (mod_side),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_code (segment_code),
		.led_value    (led_value)
	);

endmodule
